[rtl/rie_pkg.sv]
// Package for the RV32 instruction encoder: transfer structs, format and
// error codes, opcode constants and the mnemonic lookup function.
// Has no dependencies; every module of the encoder imports it.
`timescale 1ns / 1ps
`default_nettype none

package rie_pkg;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;

  typedef enum logic [2:0] {
    FMT_R,
    FMT_I,
    FMT_S,
    FMT_SB,
    FMT_U,
    FMT_UJ,
    FMT_BAD
  } fmt_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_UNKNOWN_OP   = 3'd1,
    ERR_IMM_RANGE    = 3'd2,
    ERR_BRANCH_ODD   = 3'd3,
    ERR_BRANCH_RANGE = 3'd4,
    ERR_JUMP_RANGE   = 3'd5
  } err_e;

  typedef enum logic [4:0] {
    OP_ADD, OP_AND, OP_OR, OP_SLL, OP_SLT, OP_SRA, OP_SRL, OP_SUB,
    OP_XOR, OP_MUL, OP_DIV, OP_REM,
    OP_ADDI, OP_ANDI, OP_ORI, OP_LB, OP_LH, OP_LW, OP_LD, OP_JALR,
    OP_SB, OP_SH, OP_SW, OP_SD,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE,
    OP_LUI, OP_AUIPC, OP_JAL, OP_UNKNOWN
  } op_e;

  typedef struct packed {
    logic [4:0]         req_type;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] imm;
    logic               use_target;
    logic [31:0]        target_addr;
    logic [31:0]        pc;
  } req_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [2:0]  error_code;
  } rsp_t;

  typedef struct packed {
    fmt_e       fmt;
    logic [6:0] opcode;
    logic [2:0] funct3;
    logic [6:0] funct7;
  } op_desc_t;

  typedef struct packed {
    op_desc_t    desc;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] off;
  } enc_t;

  function automatic op_desc_t op_lookup(input logic [4:0] req_type);
    op_desc_t d;
    d = '{fmt: FMT_BAD, opcode: 7'd0, funct3: 3'd0, funct7: F7_BASE};
    case (op_e'(req_type))
      OP_ADD:   d = '{FMT_R, OPC_OP, 3'd0, F7_BASE};
      OP_AND:   d = '{FMT_R, OPC_OP, 3'd7, F7_BASE};
      OP_OR:    d = '{FMT_R, OPC_OP, 3'd6, F7_BASE};
      OP_SLL:   d = '{FMT_R, OPC_OP, 3'd1, F7_BASE};
      OP_SLT:   d = '{FMT_R, OPC_OP, 3'd2, F7_BASE};
      OP_SRA:   d = '{FMT_R, OPC_OP, 3'd5, F7_ALT};
      OP_SRL:   d = '{FMT_R, OPC_OP, 3'd5, F7_BASE};
      OP_SUB:   d = '{FMT_R, OPC_OP, 3'd0, F7_ALT};
      OP_XOR:   d = '{FMT_R, OPC_OP, 3'd4, F7_BASE};
      OP_MUL:   d = '{FMT_R, OPC_OP, 3'd0, F7_MUL};
      OP_DIV:   d = '{FMT_R, OPC_OP, 3'd4, F7_MUL};
      OP_REM:   d = '{FMT_R, OPC_OP, 3'd6, F7_MUL};
      OP_ADDI:  d = '{FMT_I, OPC_OP_IMM, 3'd0, F7_BASE};
      OP_ANDI:  d = '{FMT_I, OPC_OP_IMM, 3'd7, F7_BASE};
      OP_ORI:   d = '{FMT_I, OPC_OP_IMM, 3'd6, F7_BASE};
      OP_LB:    d = '{FMT_I, OPC_LOAD, 3'd0, F7_BASE};
      OP_LH:    d = '{FMT_I, OPC_LOAD, 3'd1, F7_BASE};
      OP_LW:    d = '{FMT_I, OPC_LOAD, 3'd2, F7_BASE};
      OP_LD:    d = '{FMT_I, OPC_LOAD, 3'd3, F7_BASE};
      OP_JALR:  d = '{FMT_I, OPC_JALR, 3'd0, F7_BASE};
      OP_SB:    d = '{FMT_S, OPC_STORE, 3'd0, F7_BASE};
      OP_SH:    d = '{FMT_S, OPC_STORE, 3'd1, F7_BASE};
      OP_SW:    d = '{FMT_S, OPC_STORE, 3'd2, F7_BASE};
      OP_SD:    d = '{FMT_S, OPC_STORE, 3'd3, F7_BASE};
      OP_BEQ:   d = '{FMT_SB, OPC_BRANCH, 3'd0, F7_BASE};
      OP_BNE:   d = '{FMT_SB, OPC_BRANCH, 3'd1, F7_BASE};
      OP_BLT:   d = '{FMT_SB, OPC_BRANCH, 3'd4, F7_BASE};
      OP_BGE:   d = '{FMT_SB, OPC_BRANCH, 3'd5, F7_BASE};
      OP_LUI:   d = '{FMT_U, OPC_LUI, 3'd0, F7_BASE};
      OP_AUIPC: d = '{FMT_U, OPC_AUIPC, 3'd0, F7_BASE};
      OP_JAL:   d = '{FMT_UJ, OPC_JAL, 3'd0, F7_BASE};
      default:  d = '{FMT_BAD, 7'd0, 3'd0, F7_BASE};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/rie_offset.sv]
// Front stage of the encoder: looks up the mnemonic and selects the offset:
// the label target minus the PC for branch and jump formats with use_target,
// else the literal immediate. Depends on rie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rie_offset (
  input  rie_pkg::req_t req_i,
  output rie_pkg::enc_t enc_o
);
  import rie_pkg::*;

  op_desc_t    desc;
  logic        pc_rel;
  logic [31:0] rel_off;

  assign desc    = op_lookup(req_i.req_type);
  assign pc_rel  = req_i.use_target && (desc.fmt == FMT_SB || desc.fmt == FMT_UJ);
  assign rel_off = req_i.target_addr - req_i.pc;

  always_comb begin
    enc_o.desc = desc;
    enc_o.rd   = req_i.rd;
    enc_o.rs1  = req_i.rs1;
    enc_o.rs2  = req_i.rs2;
    enc_o.off  = pc_rel ? rel_off : req_i.imm;
  end

endmodule

`default_nettype wire

[rtl/rie_encode.sv]
// Back stage of the encoder: range checks on the offset and bit placement
// into the R, I, S, SB, U and UJ formats. Depends on rie_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rie_encode (
  input  rie_pkg::enc_t enc_i,
  output rie_pkg::rsp_t rsp_o
);
  import rie_pkg::*;

  logic [31:0] off;
  logic        fits12;
  logic        fits13;
  logic        fits20;
  logic        fits21;
  logic [31:0] word;
  err_e        err;

  assign off    = enc_i.off;
  assign fits12 = (off[31:11] == {21{off[11]}});
  assign fits13 = (off[31:12] == {20{off[12]}});
  assign fits20 = (off[31:19] == {13{off[19]}});
  assign fits21 = (off[31:20] == {12{off[20]}});

  always_comb begin
    word = 32'd0;
    err  = ERR_NONE;
    case (enc_i.desc.fmt)
      FMT_R: begin
        word = {enc_i.desc.funct7, enc_i.rs2, enc_i.rs1, enc_i.desc.funct3,
                enc_i.rd, enc_i.desc.opcode};
      end
      FMT_I: begin
        if (!fits12) begin
          err = ERR_IMM_RANGE;
        end else begin
          word = {off[11:0], enc_i.rs1, enc_i.desc.funct3, enc_i.rd,
                  enc_i.desc.opcode};
        end
      end
      FMT_S: begin
        if (!fits12) begin
          err = ERR_IMM_RANGE;
        end else begin
          word = {off[11:5], enc_i.rs2, enc_i.rs1, enc_i.desc.funct3, off[4:0],
                  enc_i.desc.opcode};
        end
      end
      FMT_SB: begin
        if (off[0]) begin
          err = ERR_BRANCH_ODD;
        end else if (!fits13) begin
          err = ERR_BRANCH_RANGE;
        end else begin
          word = {off[12], off[10:5], enc_i.rs2, enc_i.rs1, enc_i.desc.funct3,
                  off[4:1], off[11], enc_i.desc.opcode};
        end
      end
      FMT_U: begin
        if (!fits20) begin
          err = ERR_IMM_RANGE;
        end else begin
          word = {off[19:0], enc_i.rd, enc_i.desc.opcode};
        end
      end
      FMT_UJ: begin
        if (!fits21) begin
          err = ERR_JUMP_RANGE;
        end else begin
          word = {off[20], off[10:1], off[11], off[19:12], enc_i.rd,
                  enc_i.desc.opcode};
        end
      end
      default: begin
        err = ERR_UNKNOWN_OP;
      end
    endcase
  end

  assign rsp_o.instr_word = word;
  assign rsp_o.error_code = err;

endmodule

`default_nettype wire

[rtl/riscv_instruction_encoder.sv]
// Top level of the RV32 instruction encoder: handshake, stage registers and
// the two encoder stages. Depends on rie_pkg, rie_offset and rie_encode.
`timescale 1ns / 1ps
`default_nettype none

// One instruction is accepted on every cycle in which start_i is high; busy_o
// is never raised. The result appears on rsp_o with done_o high once the
// transfer has passed both register stages, for one cycle only, and must be
// taken then since the receiver cannot stall the block. There are two register
// stages: the first holds the looked-up operation and the selected offset
// (including the target minus PC subtraction), the second holds the encoded
// word and error code. Results leave in the order the instructions came in.
module riscv_instruction_encoder (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start_i,
  output logic           busy_o,
  input  rie_pkg::req_t  req_i,
  output logic           done_o,
  output rie_pkg::rsp_t  rsp_o
);
  import rie_pkg::*;

  logic accept;
  enc_t enc_d;
  enc_t enc_q;
  logic valid_q;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  rie_offset u_offset (
    .req_i (req_i),
    .enc_o (enc_d)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      enc_q <= enc_d;
    end
  end

  rie_encode u_encode (
    .enc_i (enc_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("Accepted transfer did not enter the first stage.");

  a_stage_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> done_o)
    else $error("First stage content did not produce a result.");

  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q))
    else $error("Result strobe without a preceding first stage entry.");

  a_error_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.error_code != ERR_NONE) |-> (rsp_o.instr_word == 32'd0))
    else $error("Nonzero instruction word reported together with an error.");

  a_error_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.error_code <= ERR_JUMP_RANGE))
    else $error("Error code out of its defined range.");

endmodule

`default_nettype wire

[test/riscv_instruction_encoder_tb.sv]
// Self-checking testbench for riscv_instruction_encoder: a directed table, then random
// instructions under varying sender gaps, checked against an in-bench encoding predictor.
// Depends on rie_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module riscv_instruction_encoder_tb;
  import rie_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int ITEMS_PER_PHASE = 475;

  typedef struct {
    req_t req;
    bit   known;
    rsp_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  rsp_t pending_words[$];
  rsp_t head_word;
  int   error_count;
  int   cycle_count;

  riscv_instruction_encoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic fmt_e format_of(input op_e op);
    if (op <= OP_REM) return FMT_R;
    if (op <= OP_JALR) return FMT_I;
    if (op <= OP_SD) return FMT_S;
    if (op <= OP_BGE) return FMT_SB;
    if (op <= OP_AUIPC) return FMT_U;
    if (op == OP_JAL) return FMT_UJ;
    return FMT_BAD;
  endfunction

  function automatic rsp_t predict_encoding(input req_t r);
    op_e                op;
    fmt_e               f;
    logic [6:0]         opc;
    logic [6:0]         f7;
    logic [2:0]         f3;
    logic signed [31:0] off;
    logic [31:0]        w;
    err_e               e;
    op = op_e'(r.req_type);
    f  = format_of(op);
    e  = ERR_NONE;
    w  = '0;
    case (op)
      OP_SLL, OP_LH, OP_SH, OP_BNE:                                   f3 = 3'd1;
      OP_SLT, OP_LW, OP_SW:                                           f3 = 3'd2;
      OP_LD, OP_SD:                                                   f3 = 3'd3;
      OP_XOR, OP_DIV, OP_BLT:                                         f3 = 3'd4;
      OP_SRA, OP_SRL, OP_BGE:                                         f3 = 3'd5;
      OP_OR, OP_REM, OP_ORI:                                          f3 = 3'd6;
      OP_AND, OP_ANDI:                                                f3 = 3'd7;
      default:                                                        f3 = 3'd0;
    endcase
    case (op)
      OP_SRA, OP_SUB:         f7 = F7_ALT;
      OP_MUL, OP_DIV, OP_REM: f7 = F7_MUL;
      default:                f7 = F7_BASE;
    endcase
    case (f)
      FMT_R:   opc = OPC_OP;
      FMT_I:   opc = (op <= OP_ORI) ? OPC_OP_IMM : ((op == OP_JALR) ? OPC_JALR : OPC_LOAD);
      FMT_S:   opc = OPC_STORE;
      FMT_SB:  opc = OPC_BRANCH;
      FMT_U:   opc = (op == OP_LUI) ? OPC_LUI : OPC_AUIPC;
      default: opc = OPC_JAL;
    endcase
    if ((f == FMT_SB || f == FMT_UJ) && r.use_target) begin
      off = $signed(r.target_addr - r.pc);
    end else begin
      off = r.imm;
    end
    case (f)
      FMT_R: begin
        w = {f7, r.rs2, r.rs1, f3, r.rd, opc};
      end
      FMT_I: begin
        if (off < -2048 || off > 2047) e = ERR_IMM_RANGE;
        w = {off[11:0], r.rs1, f3, r.rd, opc};
      end
      FMT_S: begin
        if (off < -2048 || off > 2047) e = ERR_IMM_RANGE;
        w = {off[11:5], r.rs2, r.rs1, f3, off[4:0], opc};
      end
      FMT_SB: begin
        // Odd offsets are reported before out-of-range ones.
        if (off[0]) e = ERR_BRANCH_ODD;
        else if (off < -4096 || off > 4094) e = ERR_BRANCH_RANGE;
        w = {off[12], off[10:5], r.rs2, r.rs1, f3, off[4:1], off[11], opc};
      end
      FMT_U: begin
        if (off < -524288 || off > 524287) e = ERR_IMM_RANGE;
        w = {off[19:0], r.rd, opc};
      end
      FMT_UJ: begin
        if (off < -1048576 || off > 1048575) e = ERR_JUMP_RANGE;
        w = {off[20], off[10:1], off[11], off[19:12], r.rd, opc};
      end
      default: begin
        e = ERR_UNKNOWN_OP;
      end
    endcase
    if (e != ERR_NONE) w = '0;
    return '{instr_word: w, error_code: e};
  endfunction

  function automatic req_t random_instr();
    req_t r;
    fmt_e f;
    int   lo;
    int   hi;
    int   off;
    r.req_type    = 5'($urandom_range(31));
    r.rd          = 5'($urandom);
    r.rs1         = 5'($urandom);
    r.rs2         = 5'($urandom);
    r.imm         = $urandom;
    r.use_target  = 1'($urandom_range(1));
    r.target_addr = $urandom;
    r.pc          = $urandom;
    f = format_of(op_e'(r.req_type));
    case (f)
      FMT_I, FMT_S: begin lo = -2048;    hi = 2047;    end
      FMT_SB:       begin lo = -4096;    hi = 4094;    end
      FMT_U:        begin lo = -524288;  hi = 524287;  end
      FMT_UJ:       begin lo = -1048576; hi = 1048575; end
      default:      return r;
    endcase
    case ($urandom_range(9))
      0:       off = int'($urandom);
      1, 2:    off = ($urandom_range(1) ? hi : lo) + int'($urandom_range(4)) - 2;
      default: off = lo + int'($urandom_range(hi - lo));
    endcase
    if (f == FMT_SB && $urandom_range(3) != 0) off = off & ~1;
    if ((f == FMT_SB || f == FMT_UJ) && r.use_target) begin
      r.target_addr = r.pc + off;
    end else begin
      r.imm = off;
    end
    return r;
  endfunction

  function automatic dir_row_t row(input op_e op, input logic [4:0] rd, input logic [4:0] rs1,
                                   input logic [4:0] rs2, input logic [31:0] imm,
                                   input logic use_t, input logic [31:0] tgt,
                                   input logic [31:0] pc, input bit known, input rsp_t want);
    dir_row_t d;
    d.req   = '{req_type: op, rd: rd, rs1: rs1, rs2: rs2, imm: imm, use_target: use_t,
                target_addr: tgt, pc: pc};
    d.known = known;
    d.want  = want;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_instr(input req_t r, input rsp_t want);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pending_words = {pending_words, want};
  endtask

  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (rst_ni && done_o !== 1'b0) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result word", rsp_o.instr_word, 32'h0);
      end else begin
        head_word = pending_words.pop_front();
        if (rsp_o.instr_word !== head_word.instr_word)
          report_mismatch("instr_word", rsp_o.instr_word, head_word.instr_word);
        if (rsp_o.error_code !== head_word.error_code)
          report_mismatch("error_code", 32'(rsp_o.error_code), 32'(head_word.error_code));
      end
    end
  end

  initial begin
    dir_row_t directed_rows[$];
    req_t     r;
    int       gap_pct;
    error_count = 0;
    cycle_count = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    directed_rows = '{
      row(OP_ADD,     0,  0,  0, 32'd0,        0, 32'h0, 32'h0, 1,
          '{32'h00000033, ERR_NONE}),
      row(OP_SUB,    31, 31, 31, 32'hFFFFFFFF, 1, '1, '1, 0, '0),
      row(OP_UNKNOWN, 31, 31, 31, 32'h7FFFFFFF, 1, '1, 32'h0, 1,
          '{32'h0, ERR_UNKNOWN_OP}),
      row(OP_ADDI,    1,  2,  0, 32'd2047,     0, 32'h0, 32'h0, 0, '0),
      row(OP_LW,     31, 31,  0, -32'sd2048,   0, 32'h0, 32'h0, 0, '0),
      row(OP_JALR,    5,  6,  7, 32'd2048,     0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_IMM_RANGE}),
      row(OP_ANDI,    3,  4,  0, -32'sd2049,   0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_IMM_RANGE}),
      row(OP_LB,      9, 10,  0, 32'h80000000, 0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_IMM_RANGE}),
      row(OP_SW,      0, 31, 31, 32'd2047,     0, 32'h0, 32'h0, 0, '0),
      row(OP_SD,      0,  1,  2, -32'sd2048,   0, 32'h0, 32'h0, 0, '0),
      row(OP_SB,      0,  1,  2, 32'd2048,     0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_IMM_RANGE}),
      row(OP_BEQ,     0, 31, 31, 32'd4094,     0, 32'h0, 32'h0, 0, '0),
      row(OP_BLT,     0,  7,  8, -32'sd4096,   0, 32'h0, 32'h0, 0, '0),
      row(OP_BGE,     0,  7,  8, 32'd4096,     0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_BRANCH_RANGE}),
      row(OP_BNE,     0,  7,  8, 32'd4095,     0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_BRANCH_ODD}),
      row(OP_BEQ,     0,  7,  8, -32'sd4097,   0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_BRANCH_ODD}),
      row(OP_BNE,     0,  1,  2, 32'd0,        1, 32'h0, 32'hFFFFF000, 1,
          '{32'h0, ERR_BRANCH_RANGE}),
      row(OP_BLT,     0,  3,  4, 32'd1,        1, 32'h10, 32'h20, 0, '0),
      row(OP_LUI,    31,  0,  0, 32'd524287,   0, 32'h0, 32'h0, 0, '0),
      row(OP_AUIPC,  17,  0,  0, -32'sd524288, 0, 32'h0, 32'h0, 0, '0),
      row(OP_LUI,     1,  0,  0, 32'd524288,   0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_IMM_RANGE}),
      row(OP_JAL,    31,  0,  0, 32'd1048575,  0, 32'h0, 32'h0, 0, '0),
      row(OP_JAL,     1,  0,  0, -32'sd1048576, 0, 32'h0, 32'h0, 0, '0),
      row(OP_JAL,     1,  0,  0, 32'd1048576,  0, 32'h0, 32'h0, 1,
          '{32'h0, ERR_JUMP_RANGE}),
      row(OP_JAL,     1,  0,  0, 32'd3,        1, 32'h0, 32'hFFFFFFFE, 0, '0),
      row(OP_ADDI,    2,  3,  0, 32'd4096,     1, 32'h4, 32'h0, 1,
          '{32'h0, ERR_IMM_RANGE})
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_instr(directed_rows[i].req,
                 directed_rows[i].known ? directed_rows[i].want
                                        : predict_encoding(directed_rows[i].req));
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 9 : ((phase == 1) ? 77 : 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sender_gap(gap_pct);
        r = random_instr();
        send_instr(r, predict_encoding(r));
      end
      // The sender holds off here until every pending transfer has produced its result.
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
